// ----- rtl/spectral_divergence_free_projection_unit_defines.svh -----
// Assertion macros shared by the projection unit RTL.
`ifndef SPECTRAL_DIVERGENCE_FREE_PROJECTION_UNIT_DEFINES_SVH
`define SPECTRAL_DIVERGENCE_FREE_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SDFP_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define SDFP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/sdfp_pkg.sv -----
// Package with widths, register indexes, types and helpers of the projection unit.
`timescale 1ns / 1ps

package sdfp_pkg;

    localparam int MAX_GRID   = 1024;
    localparam int GRID_W     = 11;
    localparam int FREQ_W     = 10;
    localparam int DATA_W     = 32;
    localparam int WAVE_W     = 11;
    localparam int SQ_W       = 21;
    localparam int SUM_W      = 22;
    localparam int GC_W       = 43;
    localparam int DIVG_W     = 45;
    localparam int AG_W       = 10;
    localparam int AD_W       = 44;
    localparam int MAG_W      = 55;
    localparam int Q_W        = 64;
    localparam int NDIV       = 16;
    localparam int DIV_STEPS  = Q_W / NDIV;
    localparam int NOUT       = 6;
    localparam int NAXIS      = 3;
    localparam int IDX_W      = 2;

    localparam logic [GRID_W-1:0] GRID_RESET  = GRID_W'(256);
    localparam logic [DATA_W-1:0] SCALE_RESET = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_A = 2'd0,
        REG_GRID_B = 2'd1,
        REG_GRID_C = 2'd2,
        REG_SCALE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [WAVE_W-1:0] w;
        logic signed [WAVE_W-1:0] g;
    } wave_t;

    typedef struct packed {
        logic [Q_W-1:0]   num;
        logic [SUM_W-1:0] rem;
    } div_t;

    // Clamp a written grid size into the supported range.
    function automatic logic [GRID_W-1:0] clamp_grid(input logic [DATA_W-1:0] v);
        logic [GRID_W-1:0] t;
        t = v[GRID_W-1:0];
        if (t < GRID_W'(2)) begin
            t = GRID_W'(2);
        end else if (t > GRID_W'(MAX_GRID)) begin
            t = GRID_W'(MAX_GRID);
        end
        return t;
    endfunction

    // Wavenumber and gradient wavenumber of one axis.
    function automatic wave_t axis_wave(input logic [FREQ_W-1:0] x,
                                        input logic [GRID_W-1:0] n);
        wave_t             r;
        logic [GRID_W-1:0] half;
        logic [GRID_W:0]   diff;
        half = n >> 1;
        diff = {2'b00, x} - {1'b0, n};
        if ({1'b0, x} > half) begin
            r.w = diff[WAVE_W-1:0];
        end else begin
            r.w = {1'b0, x};
        end
        r.g = ({1'b0, x} == half) ? '0 : r.w;
        return r;
    endfunction

    // Saturate a rounded magnitude and apply the sign.
    function automatic logic [DATA_W-1:0] sat_out(input logic [MAG_W-1:0] mag,
                                                 input logic neg);
        logic [DATA_W-1:0] m;
        if (neg) begin
            m = (mag > MAG_W'(33'h080000000)) ? 32'h80000000 : mag[DATA_W-1:0];
            return DATA_W'(0) - m;
        end
        m = (mag > MAG_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : mag[DATA_W-1:0];
        return m;
    endfunction

endpackage

// ----- rtl/spectral_divergence_free_projection_unit.sv -----
// Pipelined spectral divergence-removal projection of one Fourier coefficient per word.
// Takes one coefficient word per cycle and returns its projected gradient word after its
// stages (input register, wavenumber products, sums, |g|*|D| with divider setup, 16 radix-16
// divider stages forming the 64-bit factor fft_scale*2^32/S, 32x32 partial products,
// rounding sum, saturating output register). Sustained rate is one word per cycle; a stall
// on the result side fills bubbles first and then holds the whole pipeline.
`timescale 1ns / 1ps
`include "spectral_divergence_free_projection_unit_defines.svh"

module spectral_divergence_free_projection_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sdfp_pkg::IDX_W-1:0]        cfg_index,
    input  logic [sdfp_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sdfp_pkg::FREQ_W-1:0]       s_freq_a,
    input  logic [sdfp_pkg::FREQ_W-1:0]       s_freq_b,
    input  logic [sdfp_pkg::FREQ_W-1:0]       s_freq_c,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_a_re,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_a_im,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_b_re,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_b_im,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_c_re,
    input  logic signed [sdfp_pkg::DATA_W-1:0] s_comp_c_im,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_a_re,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_a_im,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_b_re,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_b_im,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_c_re,
    output logic signed [sdfp_pkg::DATA_W-1:0] m_proj_c_im
);
    import sdfp_pkg::*;

    // One divider stage: DIV_STEPS restoring steps, quotient bits shift into num.
    function automatic div_t div_chunk(input div_t d, input logic [SUM_W-1:0] sum);
        div_t           r;
        logic [SUM_W:0] t;
        r = d;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {r.rem, r.num[Q_W-1]};
            if (t >= {1'b0, sum}) begin
                t = t - {1'b0, sum};
                r.num = {r.num[Q_W-2:0], 1'b1};
            end else begin
                r.num = {r.num[Q_W-2:0], 1'b0};
            end
            r.rem = t[SUM_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [GRID_W-1:0] grid_a_reg, grid_b_reg, grid_c_reg;
    logic [DATA_W-1:0] scale_reg;

    // Pipeline registers
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, mv_reg;
    logic signed [WAVE_W-1:0]  w1_reg [NAXIS];
    logic signed [WAVE_W-1:0]  g1_reg [NAXIS];
    logic signed [DATA_W-1:0]  c1_reg [NOUT];
    logic [SQ_W-1:0]           sq2_reg [NAXIS];
    logic signed [WAVE_W-1:0]  g2_reg [NAXIS];
    logic signed [GC_W-1:0]    gc2_reg [NOUT];
    logic [SUM_W-1:0]          sum3_reg;
    logic signed [WAVE_W-1:0]  g3_reg [NAXIS];
    logic signed [DIVG_W-1:0]  d3_reg [2];
    logic [SUM_W-1:0]          sum4_reg;
    logic [Q_W-1:0]            num4_reg;
    logic [MAG_W-1:0]          p4_reg [NOUT];
    logic                      neg4_reg [NOUT];
    logic                      dv_reg [NDIV];
    div_t                      dd_reg [NDIV];
    logic [SUM_W-1:0]          dsum_reg [NDIV];
    logic [MAG_W-1:0]          dp_reg [NDIV][NOUT];
    logic                      dneg_reg [NDIV][NOUT];
    logic [Q_W-1:0]            ll5_reg [NOUT];
    logic [Q_W-1:0]            lh5_reg [NOUT];
    logic [Q_W-1:0]            hl5_reg [NOUT];
    logic [Q_W-1:0]            hh5_reg [NOUT];
    logic                      neg5_reg [NOUT];
    logic [MAG_W-1:0]          mag6_reg [NOUT];
    logic                      neg6_reg [NOUT];
    logic [DATA_W-1:0]         out_reg [NOUT];

    // Stage enables
    logic en1, en2, en3, en4, en5, en6, en_o;
    logic den [NDIV];

    // Let each stage advance when it is empty or the next one moves
    always_comb begin
        en_o = !mv_reg || m_ready;
        en6  = !v6_reg || en_o;
        en5  = !v5_reg || en6;
        den[NDIV-1] = !dv_reg[NDIV-1] || en5;
        for (int k = NDIV - 2; k >= 0; k--) begin
            den[k] = !dv_reg[k] || den[k+1];
        end
        en4 = !v4_reg || den[0];
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
    end

    assign s_ready = en1;
    assign m_valid = mv_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_a_reg <= GRID_RESET;
            grid_b_reg <= GRID_RESET;
            grid_c_reg <= GRID_RESET;
            scale_reg  <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GRID_A: grid_a_reg <= clamp_grid(cfg_wdata);
                REG_GRID_B: grid_b_reg <= clamp_grid(cfg_wdata);
                REG_GRID_C: grid_c_reg <= clamp_grid(cfg_wdata);
                REG_SCALE:  scale_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            mv_reg <= 1'b0;
            for (int k = 0; k < NDIV; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (den[0]) dv_reg[0] <= v4_reg;
            for (int k = 1; k < NDIV; k++) begin
                if (den[k]) dv_reg[k] <= dv_reg[k-1];
            end
            if (en5) v5_reg <= dv_reg[NDIV-1];
            if (en6) v6_reg <= v5_reg;
            if (en_o) mv_reg <= v6_reg;
        end
    end

    // Stage 1: capture the word and form wavenumbers
    wave_t wv [NAXIS];
    always_comb begin
        wv[0] = axis_wave(s_freq_a, grid_a_reg);
        wv[1] = axis_wave(s_freq_b, grid_b_reg);
        wv[2] = axis_wave(s_freq_c, grid_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int i = 0; i < NAXIS; i++) begin
                w1_reg[i] <= wv[i].w;
                g1_reg[i] <= wv[i].g;
            end
            c1_reg[0] <= s_comp_a_re;
            c1_reg[1] <= s_comp_a_im;
            c1_reg[2] <= s_comp_b_re;
            c1_reg[3] <= s_comp_b_im;
            c1_reg[4] <= s_comp_c_re;
            c1_reg[5] <= s_comp_c_im;
        end
    end

    // Stage 2: squares and gradient-component products
    logic signed [SUM_W-1:0] sq_full [NAXIS];
    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            sq_full[i] = SUM_W'(w1_reg[i]) * SUM_W'(w1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int i = 0; i < NAXIS; i++) begin
                sq2_reg[i] <= sq_full[i][SQ_W-1:0];
                g2_reg[i]  <= g1_reg[i];
            end
            for (int j = 0; j < NOUT; j++) begin
                gc2_reg[j] <= GC_W'(g1_reg[j/2]) * GC_W'(c1_reg[j]);
            end
        end
    end

    // Stage 3: norm and divergence sums
    always_ff @(posedge aclk) begin
        if (en3) begin
            sum3_reg <= SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
            for (int p = 0; p < 2; p++) begin
                d3_reg[p] <= DIVG_W'(gc2_reg[p]) + DIVG_W'(gc2_reg[2+p])
                           + DIVG_W'(gc2_reg[4+p]);
            end
            for (int i = 0; i < NAXIS; i++) begin
                g3_reg[i] <= g2_reg[i];
            end
        end
    end

    // Stage 4: magnitudes of g*D, signs, divider numerator
    logic [WAVE_W-1:0] ag_full [NAXIS];
    logic [DIVG_W-1:0] ad_full [2];
    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            ag_full[i] = g3_reg[i][WAVE_W-1] ? WAVE_W'(0) - g3_reg[i] : g3_reg[i];
        end
        for (int p = 0; p < 2; p++) begin
            ad_full[p] = d3_reg[p][DIVG_W-1] ? DIVG_W'(0) - d3_reg[p] : d3_reg[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            sum4_reg <= sum3_reg;
            num4_reg <= {scale_reg, 32'h0} + Q_W'(sum3_reg >> 1);
            for (int j = 0; j < NOUT; j++) begin
                p4_reg[j]   <= MAG_W'(ag_full[j/2][AG_W-1:0]) * MAG_W'(ad_full[j%2][AD_W-1:0]);
                neg4_reg[j] <= (g3_reg[j/2][WAVE_W-1] == d3_reg[j%2][DIVG_W-1]);
            end
        end
    end

    // Divider stages: DIV_STEPS quotient bits each
    div_t dnext [NDIV];
    always_comb begin
        dnext[0] = div_chunk('{num: num4_reg, rem: '0}, sum4_reg);
        for (int k = 1; k < NDIV; k++) begin
            dnext[k] = div_chunk(dd_reg[k-1], dsum_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (den[0]) begin
            dd_reg[0]   <= dnext[0];
            dsum_reg[0] <= sum4_reg;
            for (int j = 0; j < NOUT; j++) begin
                dp_reg[0][j]   <= p4_reg[j];
                dneg_reg[0][j] <= neg4_reg[j];
            end
        end
        for (int k = 1; k < NDIV; k++) begin
            if (den[k]) begin
                dd_reg[k]   <= dnext[k];
                dsum_reg[k] <= dsum_reg[k-1];
                for (int j = 0; j < NOUT; j++) begin
                    dp_reg[k][j]   <= dp_reg[k-1][j];
                    dneg_reg[k][j] <= dneg_reg[k-1][j];
                end
            end
        end
    end

    // Stage 5: 32x32 partial products of p and the factor
    logic [Q_W-1:0] rq;
    assign rq = dd_reg[NDIV-1].num;

    always_ff @(posedge aclk) begin
        if (en5) begin
            for (int j = 0; j < NOUT; j++) begin
                ll5_reg[j]  <= Q_W'(dp_reg[NDIV-1][j][31:0]) * Q_W'(rq[31:0]);
                lh5_reg[j]  <= Q_W'(dp_reg[NDIV-1][j][31:0]) * Q_W'(rq[63:32]);
                hl5_reg[j]  <= Q_W'(dp_reg[NDIV-1][j][MAG_W-1:32]) * Q_W'(rq[31:0]);
                hh5_reg[j]  <= Q_W'(dp_reg[NDIV-1][j][MAG_W-1:32]) * Q_W'(rq[63:32]);
                neg5_reg[j] <= dneg_reg[NDIV-1][j];
            end
        end
    end

    // Stage 6: add partial products, round half up, keep the high word
    logic [119:0] tot [NOUT];
    always_comb begin
        for (int j = 0; j < NOUT; j++) begin
            tot[j] = 120'(ll5_reg[j]) + (120'(lh5_reg[j]) << 32) + (120'(hl5_reg[j]) << 32)
                   + (120'(hh5_reg[j]) << 64) + (120'(1) << 63);
        end
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            for (int j = 0; j < NOUT; j++) begin
                mag6_reg[j] <= tot[j][64 +: MAG_W];
                neg6_reg[j] <= neg5_reg[j];
            end
        end
    end

    // Output register: saturate and sign
    always_ff @(posedge aclk) begin
        if (en_o) begin
            for (int j = 0; j < NOUT; j++) begin
                out_reg[j] <= sat_out(mag6_reg[j], neg6_reg[j]);
            end
        end
    end

    assign m_proj_a_re = out_reg[0];
    assign m_proj_a_im = out_reg[1];
    assign m_proj_b_re = out_reg[2];
    assign m_proj_b_im = out_reg[3];
    assign m_proj_c_re = out_reg[4];
    assign m_proj_c_im = out_reg[5];

    // Checks
    `SDFP_ASSERT_IMPL(a_ready_only_on_stall, !s_ready, m_valid && !m_ready, "input held without output stall")
    `SDFP_ASSERT_IMPL(a_div_rem_bound, dv_reg[NDIV-1] && dsum_reg[NDIV-1] != '0, dd_reg[NDIV-1].rem < dsum_reg[NDIV-1], "divider remainder out of range")
    `SDFP_ASSERT_IMPL(a_zero_norm_zero_p, v4_reg && sum4_reg == '0, p4_reg[0] == '0 && p4_reg[2] == '0 && p4_reg[4] == '0 && p4_reg[1] == '0 && p4_reg[3] == '0 && p4_reg[5] == '0, "zero wavenumber gave nonzero product")
    `SDFP_ASSERT_NEXT(a_out_from_stage6, en_o && v6_reg, mv_reg, "finished word lost at output")

endmodule
